// ===== hw/rtl/fcgc_pkg.sv =====
// shared types and constants of the four-corner gradient color block
// no dependencies
`default_nettype none

package fcgc_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int NUM_CORNERS = 4;
    localparam int COLOR_W     = NUM_CH * CH_W;
    localparam int CELL_W      = 7;
    localparam int N_CFG_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int MIN_CELLS   = 2;
    // sum < 4 * 255 * (N-1) + N-1, so the quotient stays below 1024
    localparam int QUOT_W      = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = COLOR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_PER_EDGE = 3'd0,
        CFG_CORNER_UL      = 3'd1,
        CFG_CORNER_UR      = 3'd2,
        CFG_CORNER_LR      = 3'd3,
        CFG_CORNER_LL      = 3'd4
    } t_cfg_index;

    // corner order: upper-left, upper-right, lower-right, lower-left
    localparam logic [N_CFG_W-1:0] RST_CELLS_PER_EDGE = 8'd15;
    localparam logic [COLOR_W-1:0] RST_CORNER_UL      = 24'h000000;
    localparam logic [COLOR_W-1:0] RST_CORNER_UR      = 24'h0000FF;
    localparam logic [COLOR_W-1:0] RST_CORNER_LR      = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_CORNER_LL      = 24'hFF0000;

    localparam logic [CH_W-1:0] LEVEL_MAX = 8'hFF;

    function automatic logic [CH_W-1:0] channel_of(input logic [COLOR_W-1:0] color,
                                                  input int ch);
        return color[ch*CH_W +: CH_W];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/four_corner_gradient_color.sv =====
// four-corner gradient color block: grid cell in, blended rgb out
// depends on fcgc_pkg
`default_nettype none

// Each request carries one grid cell (column, row) and gives one rgb result,
// blended from four corner colors by Chebyshev-distance weights over N-1,
// floored and clamped at 255; a cell outside the grid gives white with the
// in_grid flag low. The pipeline takes one request per clock while the output
// is not stalled; from input accept to output valid it runs through weights,
// products, sums, five radix-4 stages of the restoring divider by N-1, and
// the clamp into the output register. Each stage holds its item while the
// next one is full, so bubbles close up under backpressure. Configuration
// writes are taken at any time and should land while the pipeline is empty.
module four_corner_gradient_color #(
    parameter int MAX_CELLS = 128
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // [6:0] cell_column, [13:7] cell_row, [15:14] zero
    input  wire logic [fcgc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    output      logic [fcgc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] in_grid
    output      logic                               m_axis_tuser,
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [fcgc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fcgc_pkg::COLOR_W-1:0]       i_cfg_data
);

    import fcgc_pkg::*;

    localparam int LW             = $clog2(MAX_CELLS);
    localparam int NW             = $clog2(MAX_CELLS + 1);
    localparam int WW             = (NW > N_CFG_W) ? NW : N_CFG_W;
    localparam int CW             = (LW > CELL_W) ? LW : CELL_W;
    localparam int PW             = CH_W + LW;
    localparam int SW             = LW + QUOT_W;
    localparam int DIV_STAGES     = 5;
    localparam int BITS_PER_STAGE = QUOT_W / DIV_STAGES;
    localparam int NST            = DIV_STAGES + 4;
    localparam int ST_PROD        = 1;
    localparam int ST_SUM         = 2;

    // configuration registers
    logic [N_CFG_W-1:0] r_cells_per_edge;
    logic [COLOR_W-1:0] r_corner [NUM_CORNERS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_per_edge <= RST_CELLS_PER_EDGE;
            r_corner[0]      <= RST_CORNER_UL;
            r_corner[1]      <= RST_CORNER_UR;
            r_corner[2]      <= RST_CORNER_LR;
            r_corner[3]      <= RST_CORNER_LL;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CELLS_PER_EDGE: r_cells_per_edge <= i_cfg_data[N_CFG_W-1:0];
                CFG_CORNER_UL:      r_corner[0] <= i_cfg_data;
                CFG_CORNER_UR:      r_corner[1] <= i_cfg_data;
                CFG_CORNER_LR:      r_corner[2] <= i_cfg_data;
                CFG_CORNER_LL:      r_corner[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective grid size and divisor, to be kept static by the user while items flow; not enforced here
    logic [WW-1:0] cfg_n;
    logic [WW-1:0] n_eff;
    logic [WW-1:0] n_m1;
    logic [LW-1:0] last;

    always_comb begin
        cfg_n = WW'(r_cells_per_edge);
        if (cfg_n < WW'(MIN_CELLS)) begin
            n_eff = WW'(MIN_CELLS);
        end else if (cfg_n > WW'(MAX_CELLS)) begin
            n_eff = WW'(MAX_CELLS);
        end else begin
            n_eff = cfg_n;
        end
        n_m1 = n_eff - WW'(1);
        last = n_m1[LW-1:0];
    end

    // stage enables, a stage moves when it is empty or its successor moves
    logic [NST-1:0] stage_en;
    logic [NST-1:0] r_vld;

    always_comb begin
        stage_en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign s_axis_tready = stage_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: corner weights
    function automatic logic [CW-1:0] larger(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic              in_grid;
    logic [CW-1:0]     colx;
    logic [CW-1:0]     rowx;
    logic [CW-1:0]     lastx;
    logic [CW-1:0]     inv_col;
    logic [CW-1:0]     inv_row;
    logic [CW-1:0]     corner_dist [NUM_CORNERS];
    logic [CW-1:0]     wfull [NUM_CORNERS];

    always_comb begin
        col     = s_axis_tdata[CELL_W-1:0];
        row     = s_axis_tdata[2*CELL_W-1:CELL_W];
        in_grid = (WW'(col) < n_eff) && (WW'(row) < n_eff);
        colx    = CW'(col);
        rowx    = CW'(row);
        lastx   = CW'(last);
        inv_col = lastx - colx;
        inv_row = lastx - rowx;
        corner_dist[0] = larger(colx, rowx);
        corner_dist[1] = larger(inv_col, rowx);
        corner_dist[2] = larger(inv_col, inv_row);
        corner_dist[3] = larger(colx, inv_row);
        for (int c = 0; c < NUM_CORNERS; c++) begin
            wfull[c] = lastx - corner_dist[c];
        end
    end

    logic [LW-1:0] r_w    [NUM_CORNERS];
    logic [NST-2:0] r_grid;

    // stage 1: products, stage 2: sums split into divider remainder and low bits
    logic [PW-1:0]     r_prod [NUM_CH][NUM_CORNERS];
    logic [SW-1:0]     n_sum  [NUM_CH];
    logic [LW-1:0]     r_rem  [DIV_STAGES+1][NUM_CH];
    logic [QUOT_W-1:0] r_quo  [DIV_STAGES+1][NUM_CH];
    logic [LW-1:0]     n_rem  [DIV_STAGES+1][NUM_CH];
    logic [QUOT_W-1:0] n_quo  [DIV_STAGES+1][NUM_CH];

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum[ch] = '0;
            for (int c = 0; c < NUM_CORNERS; c++) begin
                n_sum[ch] = n_sum[ch] + SW'(r_prod[ch][c]);
            end
        end
    end

    // restoring divide by n-1, two quotient bits per stage;
    // the top sum bits are already below n-1, so the remainder starts there
    always_comb begin
        logic [LW:0]       trial;
        logic [LW-1:0]     rem;
        logic [QUOT_W-1:0] x;
        trial = '0;
        rem   = '0;
        x     = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_rem[0][ch] = n_sum[ch][SW-1:QUOT_W];
            n_quo[0][ch] = n_sum[ch][QUOT_W-1:0];
        end
        for (int s = 1; s <= DIV_STAGES; s++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                rem = r_rem[s-1][ch];
                x   = r_quo[s-1][ch];
                for (int b = 0; b < BITS_PER_STAGE; b++) begin
                    trial = {rem, x[QUOT_W-1]};
                    x     = {x[QUOT_W-2:0], 1'b0};
                    if (trial >= {1'b0, last}) begin
                        trial = trial - {1'b0, last};
                        x[0]  = 1'b1;
                    end
                    rem = trial[LW-1:0];
                end
                n_rem[s][ch] = rem;
                n_quo[s][ch] = x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_grid[0] <= in_grid;
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r_w[c] <= wfull[c][LW-1:0];
            end
        end
        if (stage_en[ST_PROD]) begin
            r_grid[ST_PROD] <= r_grid[0];
            for (int ch = 0; ch < NUM_CH; ch++) begin
                for (int c = 0; c < NUM_CORNERS; c++) begin
                    r_prod[ch][c] <= PW'(channel_of(r_corner[c], ch)) * PW'(r_w[c]);
                end
            end
        end
        for (int s = 0; s <= DIV_STAGES; s++) begin
            if (stage_en[ST_SUM + s]) begin
                r_grid[ST_SUM + s] <= r_grid[ST_SUM + s - 1];
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r_rem[s][ch] <= n_rem[s][ch];
                    r_quo[s][ch] <= n_quo[s][ch];
                end
            end
        end
    end

    // output stage: clamp, white outside the grid
    logic [OUT_TDATA_W-1:0] n_out;
    logic [OUT_TDATA_W-1:0] r_out;
    logic                   r_out_grid;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (!r_grid[NST-2] || (r_quo[DIV_STAGES][ch] > QUOT_W'(LEVEL_MAX))) begin
                n_out[ch*CH_W +: CH_W] = LEVEL_MAX;
            end else begin
                n_out[ch*CH_W +: CH_W] = r_quo[DIV_STAGES][ch][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[NST-1]) begin
            r_out      <= n_out;
            r_out_grid <= r_grid[NST-2];
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_grid;

endmodule

`default_nettype wire

// ===== dv/gradient_color_checker.sv =====
// checker for four_corner_gradient_color: watches the cell, color and register channels
// keeps its own copy of the registers, predicts each color and compares it; uses fcgc_pkg
module gradient_color_checker #(
    parameter int MAX_CELLS = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // [6:0] cell_column, [13:7] cell_row, [15:14] zero
    input  logic [fcgc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    input  logic [fcgc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] in_grid
    input  logic                               m_axis_tuser,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [fcgc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fcgc_pkg::COLOR_W-1:0]       i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcgc_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            in_grid;
    } t_swatch;

    // register copy; corners in the order upper-left, upper-right, lower-right, lower-left
    logic [N_CFG_W-1:0] grid_n;
    logic [COLOR_W-1:0] corner [NUM_CORNERS];

    t_swatch color_queue [$];
    int      cells_taken;
    int      colors_seen;
    int      fail_count;

    assign o_errors  = fail_count;
    assign o_pending = cells_taken - colors_seen;

    initial begin
        fail_count = 0;
    end

    function automatic int unsigned farther(input int unsigned a, input int unsigned b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_swatch blend_cell(input int unsigned col, input int unsigned row);
        t_swatch         s;
        int unsigned     n;
        int unsigned     last;
        int unsigned     acc;
        int unsigned     q;
        int unsigned     w [NUM_CORNERS];
        logic [CH_W-1:0] lv [NUM_CH];
        n = grid_n;
        if (n < MIN_CELLS) n = MIN_CELLS;
        if (n > MAX_CELLS) n = MAX_CELLS;
        if (col >= n || row >= n) begin
            s.red     = LEVEL_MAX;
            s.green   = LEVEL_MAX;
            s.blue    = LEVEL_MAX;
            s.in_grid = 1'b0;
            return s;
        end
        // weight of a corner is last minus the chebyshev distance to it
        last = n - 1;
        w[0] = last - farther(col, row);
        w[1] = last - farther(last - col, row);
        w[2] = last - farther(last - col, last - row);
        w[3] = last - farther(col, last - row);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = 0;
            for (int k = 0; k < NUM_CORNERS; k++) begin
                acc += corner[k][ch*CH_W +: CH_W] * w[k];
            end
            q = acc / last;
            lv[ch] = (q > LEVEL_MAX) ? LEVEL_MAX : q[CH_W-1:0];
        end
        s.red     = lv[0];
        s.green   = lv[1];
        s.blue    = lv[2];
        s.in_grid = 1'b1;
        return s;
    endfunction

    task automatic match_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_swatch want;
        if (!i_rst_n) begin
            grid_n    = RST_CELLS_PER_EDGE;
            corner[0] = RST_CORNER_UL;
            corner[1] = RST_CORNER_UR;
            corner[2] = RST_CORNER_LR;
            corner[3] = RST_CORNER_LL;
            color_queue.delete();
            cells_taken <= 0;
            colors_seen <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CELLS_PER_EDGE: grid_n    = i_cfg_data[N_CFG_W-1:0];
                    CFG_CORNER_UL:      corner[0] = i_cfg_data;
                    CFG_CORNER_UR:      corner[1] = i_cfg_data;
                    CFG_CORNER_LR:      corner[2] = i_cfg_data;
                    CFG_CORNER_LL:      corner[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                color_queue.insert(color_queue.size(),
                                   blend_cell(s_axis_tdata[CELL_W-1:0],
                                              s_axis_tdata[2*CELL_W-1:CELL_W]));
                cells_taken <= cells_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                colors_seen <= colors_seen + 1;
                if (color_queue.size() == 0) begin
                    $error("color result with no cell request outstanding");
                    fail_count++;
                end else begin
                    want = color_queue.pop_front();
                    match_field("red_level", want.red, m_axis_tdata[CH_W-1:0]);
                    match_field("green_level", want.green, m_axis_tdata[2*CH_W-1:CH_W]);
                    match_field("blue_level", want.blue, m_axis_tdata[3*CH_W-1:2*CH_W]);
                    match_field("in_grid", want.in_grid, m_axis_tuser);
                end
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// top of the four_corner_gradient_color testbench: clock, reset, stimulus and verdict
// depends on fcgc_pkg, four_corner_gradient_color and gradient_color_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcgc_pkg::*;

    localparam int MAX_CELLS    = 128;
    localparam int MAX_GAP      = 19;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_ITEMS  = 102;
    localparam int HOLD_PHASE   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_IDX_W'(CFG_CORNER_LL + 1);
    localparam logic [COLOR_W-1:0]   WHITE = '1;
    localparam logic [COLOR_W-1:0]   BLACK = '0;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [COLOR_W-1:0]       i_cfg_data;
    int                       errors;
    int                       pending;

    bit                       tx_eager;
    bit                       rx_eager;
    bit                       rx_hold_req;
    logic [CFG_IDX_W-1:0]     unused_index;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    four_corner_gradient_color #(.MAX_CELLS(MAX_CELLS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    gradient_color_checker #(.MAX_CELLS(MAX_CELLS)) u_color_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    task automatic send_cell(input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-2*CELL_W){1'b0}}, row, col};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // stop offering cells and wait until every color has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COLOR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic load_setting(input logic [N_CFG_W-1:0] n, input logic [COLOR_W-1:0] ul,
                                input logic [COLOR_W-1:0] ur, input logic [COLOR_W-1:0] lr,
                                input logic [COLOR_W-1:0] ll);
        write_register(CFG_CELLS_PER_EDGE, {{(COLOR_W-N_CFG_W){1'b0}}, n});
        write_register(CFG_CORNER_UL, ul);
        write_register(CFG_CORNER_UR, ur);
        write_register(CFG_CORNER_LR, lr);
        write_register(CFG_CORNER_LL, ll);
        // an index past the register list must leave everything alone
        write_register(unused_index, COLOR_W'($urandom()));
        unused_index = (unused_index == '1) ? CFG_UNUSED_FIRST
                                            : unused_index + CFG_IDX_W'(1);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [N_CFG_W-1:0] pick_grid_size();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd2;
                    3: return 8'd128;
                    4: return 8'd129;
                    default: return 8'd255;
                endcase
            end
            1, 2: return N_CFG_W'($urandom_range(17, MAX_CELLS));
            default: return N_CFG_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? WHITE : BLACK;
        return COLOR_W'($urandom());
    endfunction

    // color receiver: a fresh stall per result, one long hold-off on request
    initial begin : color_sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [N_CFG_W-1:0] n;
        int                 span;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        tx_eager      = 1'b0;
        rx_eager      = 1'b0;
        rx_hold_req   = 1'b0;
        unused_index  = CFG_UNUSED_FIRST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: corners, center, just outside, far outside
        send_cell(0, 0);
        send_cell(14, 0);
        send_cell(14, 14);
        send_cell(0, 14);
        send_cell(7, 7);
        send_cell(15, 3);
        send_cell(3, 15);
        send_cell(127, 127);
        send_cell(85, 42);
        wait_drained();

        // smallest grid, all corners white
        load_setting(8'd2, WHITE, WHITE, WHITE, WHITE);
        send_cell(0, 0);
        send_cell(1, 1);
        send_cell(1, 0);
        send_cell(2, 1);
        send_cell(0, 2);
        wait_drained();

        // largest grid
        load_setting(8'd128, WHITE, BLACK, WHITE, BLACK);
        send_cell(127, 127);
        send_cell(0, 127);
        send_cell(64, 63);
        send_cell(63, 64);
        send_cell(42, 85);
        wait_drained();

        // center of a bright 3x3 grid overflows and clamps
        load_setting(8'd3, WHITE, WHITE, WHITE, WHITE);
        send_cell(1, 1);
        send_cell(3, 0);
        wait_drained();

        // sizes below two and above the limit
        load_setting(8'd0, 24'h123456, 24'hABCDEF, WHITE, 24'h00FF80);
        send_cell(1, 1);
        wait_drained();
        load_setting(8'd1, 24'h80FF01, BLACK, 24'h7F7F7F, WHITE);
        send_cell(1, 0);
        wait_drained();
        load_setting(8'd255, 24'hFF00FF, 24'h010203, 24'hFEFDFC, 24'h55AA55);
        send_cell(127, 0);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            n = pick_grid_size();
            load_setting(n, pick_color(), pick_color(), pick_color(), pick_color());
            span = (n < MIN_CELLS) ? MIN_CELLS : (n > MAX_CELLS) ? MAX_CELLS : n;
            if (p == HOLD_PHASE) begin
                // receiver stops for a long stretch while cells keep coming
                tx_eager    = 1'b1;
                rx_eager    = 1'b0;
                rx_hold_req = 1'b1;
            end else begin
                tx_eager = ($urandom_range(0, 3) == 0);
                rx_eager = ($urandom_range(0, 3) == 0);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 85)
                    send_cell(CELL_W'($urandom_range(0, span - 1)),
                              CELL_W'($urandom_range(0, span - 1)));
                else
                    send_cell(CELL_W'($urandom_range(0, MAX_CELLS - 1)),
                              CELL_W'($urandom_range(0, MAX_CELLS - 1)));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
